/* hdl/awa_pkg.sv */
package awa_pkg;

	// field and state widths
	localparam int RAW_W   = 32;
	localparam int VAL_W   = 26;
	localparam int SUM_W   = 34;
	localparam int CNT_W   = 8;
	localparam int RES_W   = 5;
	localparam int VREF_W  = 23;
	localparam int CODE_W  = 26;
	localparam int VOLT_W  = 25;
	localparam int PROD_W  = CODE_W + 1 + VREF_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = VREF_W;

	// serial unit step counters
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam int MUL_CNT_W = $clog2(VREF_W);

	// raw word field: bits 31 and 30 ignored, low 4 bits dropped
	localparam int VAL_LSB = 4;

	// resolution limits and full scale
	localparam logic [RES_W-1:0] RES_MIN         = RES_W'(12);
	localparam logic [RES_W-1:0] RES_MAX         = RES_W'(24);
	localparam logic [RES_W-1:0] FULL_SCALE_LOG2 = RES_W'(24);

	// sign bit offset, 2^25
	localparam logic [CODE_W-1:0] SIGN_OFFSET = CODE_W'(33554432);

	// reset values of the registers
	localparam logic [RES_W-1:0]  RES_RESET  = RES_W'(24);
	localparam logic [CNT_W-1:0]  SPR_RESET  = CNT_W'(1);
	localparam logic [VREF_W-1:0] VREF_RESET = VREF_W'(2500000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_VREF       = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_MUL,
		ST_HOLD
	} state_t;

endpackage

/* hdl/awa_div.sv */
module awa_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [awa_pkg::SUM_W-1:0]       dividend,
	input  logic [awa_pkg::CNT_W-1:0]       divisor,
	output logic                            done,
	output logic [awa_pkg::SUM_W-1:0]       quotient
);

	logic [awa_pkg::SUM_W-1:0]     quo_q;
	logic [awa_pkg::CNT_W-1:0]     rem_q;
	logic [awa_pkg::CNT_W-1:0]     dvs_q;
	logic [awa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [awa_pkg::CNT_W:0]   trial;
	logic [awa_pkg::CNT_W+1:0] diff;
	logic                      fits;

	// restoring step, one quotient bit per cycle
	assign trial = {rem_q, quo_q[awa_pkg::SUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign fits  = !diff[awa_pkg::CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == awa_pkg::DIV_CNT_W'(awa_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[awa_pkg::SUM_W-2:0], fits};
			rem_q <= fits ? diff[awa_pkg::CNT_W-1:0] : trial[awa_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/awa_mul.sv */
module awa_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [awa_pkg::CODE_W-1:0]   mcand,
	input  logic [awa_pkg::VREF_W-1:0]          mplier,
	output logic                                done,
	output logic signed [awa_pkg::PROD_W-1:0]   product
);

	localparam int HI_W = awa_pkg::CODE_W + 1;

	logic [awa_pkg::PROD_W-1:0]    p_q;
	logic [awa_pkg::CODE_W-1:0]    mcand_q;
	logic [awa_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [HI_W-1:0] hi;
	logic [HI_W-1:0] addend;
	logic [HI_W-1:0] hi_sum;

	// shift-add, one multiplier bit per cycle, lsb first
	assign hi     = p_q[awa_pkg::PROD_W-1:awa_pkg::VREF_W];
	assign addend = p_q[0] ? {mcand_q[awa_pkg::CODE_W-1], mcand_q} : '0;
	assign hi_sum = hi + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == awa_pkg::MUL_CNT_W'(awa_pkg::VREF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q     <= {{HI_W{1'b0}}, mplier};
			mcand_q <= mcand;
		end else if (busy_q) begin
			p_q <= {hi_sum[HI_W-1], hi_sum, p_q[awa_pkg::VREF_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = $signed(p_q);

endmodule

/* hdl/adc_word_average_scale.sv */
// channel | dir | transfer when       | payload
// cfg     | in  | cfg_wr_en           | cfg_index, cfg_data
// in      | in  | in_valid & in_ready | raw_word
// out     | out | out_valid & out_ready | average_code, voltage_microvolts
//
// a word that does not close an average only adds to the accumulator, the next may follow at once
// a closing word passes through 34 steps of the bit-serial divider and
// 23 steps of the bit-serial multiplier, then waits in ST_HOLD for the output register
// in_ready is low from a closing word until its result sits in the output register
// one finished result waits in the output register while new words are taken
// arst_n clears config to its defaults, the accumulator, the count and out_valid
module adc_word_average_scale (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [awa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [awa_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [awa_pkg::RAW_W-1:0]             raw_word,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [awa_pkg::CODE_W-1:0]     average_code,
	output logic signed [awa_pkg::VOLT_W-1:0]     voltage_microvolts
);

	// configuration registers
	logic [awa_pkg::RES_W-1:0]  res_q;
	logic [awa_pkg::CNT_W-1:0]  spr_q;
	logic [awa_pkg::VREF_W-1:0] vref_q;

	// accumulator state
	logic [awa_pkg::SUM_W-1:0] sum_q;
	logic [awa_pkg::CNT_W-1:0] taken_q;

	// output register
	logic                              out_valid_q;
	logic signed [awa_pkg::CODE_W-1:0] code_out_q;
	logic signed [awa_pkg::VOLT_W-1:0] volt_out_q;

	// code of the average in flight
	logic signed [awa_pkg::CODE_W-1:0] code_q;

	awa_pkg::state_t state_q;
	awa_pkg::state_t state_d;

	logic                              in_xfer;
	logic                              out_xfer;
	logic                              out_free;
	logic [awa_pkg::VAL_W-1:0]         val;
	logic [awa_pkg::SUM_W-1:0]         sum_next;
	logic [awa_pkg::CNT_W-1:0]         taken_next;
	logic [awa_pkg::CNT_W-1:0]         target;
	logic                              closing;
	logic [awa_pkg::RES_W-1:0]         res_c;
	logic [awa_pkg::RES_W-1:0]         shift_c;
	logic [awa_pkg::CODE_W-1:0]        avg_c;
	logic signed [awa_pkg::CODE_W-1:0] code_c;
	logic signed [awa_pkg::PROD_W-1:0] prod_sh;
	logic signed [awa_pkg::VOLT_W-1:0] volt_c;

	logic                              div_start;
	logic                              div_done;
	logic [awa_pkg::SUM_W-1:0]         div_quo;
	logic                              mul_start;
	logic                              mul_done;
	logic signed [awa_pkg::PROD_W-1:0] mul_prod;
	logic                              load_out;

	// config write port, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= awa_pkg::RES_RESET;
			spr_q  <= awa_pkg::SPR_RESET;
			vref_q <= awa_pkg::VREF_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				awa_pkg::REG_RESOLUTION: res_q  <= cfg_data[awa_pkg::RES_W-1:0];
				awa_pkg::REG_SAMPLES:    spr_q  <= cfg_data[awa_pkg::CNT_W-1:0];
				awa_pkg::REG_VREF:       vref_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// resolution clamped to 12..24, shift is what is dropped below it
	always_comb begin
		if (res_q < awa_pkg::RES_MIN) begin
			res_c = awa_pkg::RES_MIN;
		end else if (res_q > awa_pkg::RES_MAX) begin
			res_c = awa_pkg::RES_MAX;
		end else begin
			res_c = res_q;
		end
	end
	assign shift_c = awa_pkg::FULL_SCALE_LOG2 - res_c;

	// accumulate, a count of zero acts as one
	assign val        = raw_word[awa_pkg::VAL_LSB +: awa_pkg::VAL_W];
	assign sum_next   = sum_q + {{(awa_pkg::SUM_W - awa_pkg::VAL_W){1'b0}}, val};
	assign taken_next = taken_q + 1'b1;
	assign target     = (spr_q == '0) ? awa_pkg::CNT_W'(1) : spr_q;
	assign closing    = (taken_next >= target);

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign out_free = !out_valid_q || out_ready;

	// quotient fits 26 bits, then shift and remove the shifted sign offset
	assign avg_c  = div_quo[awa_pkg::CODE_W-1:0];
	assign code_c = $signed((avg_c >> shift_c) - (awa_pkg::SIGN_OFFSET >> shift_c));

	// floor of product over 2^resolution, arithmetic shift keeps the sign
	assign prod_sh = mul_prod >>> res_c;
	assign volt_c  = prod_sh[awa_pkg::VOLT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awa_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			awa_pkg::ST_ACC: begin
				in_ready = 1'b1;
				if (in_valid && closing) begin
					div_start = 1'b1;
					state_d   = awa_pkg::ST_DIV;
				end
			end
			awa_pkg::ST_DIV: begin
				if (div_done) begin
					mul_start = 1'b1;
					state_d   = awa_pkg::ST_MUL;
				end
			end
			awa_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d = awa_pkg::ST_HOLD;
				end
			end
			awa_pkg::ST_HOLD: begin
				// wait for the output register to drain
				if (out_free) begin
					load_out = 1'b1;
					state_d  = awa_pkg::ST_ACC;
				end
			end
			default: state_d = awa_pkg::ST_ACC;
		endcase
	end

	// accumulator and word count, cleared when an average closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (in_xfer) begin
			if (closing) begin
				sum_q   <= '0;
				taken_q <= '0;
			end else begin
				sum_q   <= sum_next;
				taken_q <= taken_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			code_q <= code_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			code_out_q <= code_q;
			volt_out_q <= volt_c;
		end
	end

	// sum divided by the words actually taken
	awa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (taken_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	// signed code times reference
	awa_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (code_c),
		.mplier  (vref_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign out_valid          = out_valid_q;
	assign average_code       = code_out_q;
	assign voltage_microvolts = volt_out_q;

	// a closing word leaves the accumulator empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && closing) |=> (sum_q == '0 && taken_q == '0))
		else $error("accumulator not cleared after closing word");

	// the count stays below the largest target, so it never wraps
	assert property (@(posedge clk) disable iff (!arst_n)
		taken_q != '1)
		else $error("word count reached its wrap value");

	// serial units finish only in their own phase
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == awa_pkg::ST_DIV))
		else $error("divider finished outside the divide phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == awa_pkg::ST_MUL))
		else $error("multiplier finished outside the multiply phase");

	// a new result appears only out of the hold phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == awa_pkg::ST_HOLD))
		else $error("result appeared without the hold phase");

endmodule
